// ===== sv/pchd_pkg.sv =====
// pchd_pkg: shared widths, constants, register codes and types of the pump current
// hold detector. No dependencies.
`default_nettype none

package pchd_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int NUM_CHANNELS = 3;
  localparam int NPUMP        = 3;
  localparam int STAMP_W      = 32;

  // filter sum: sample + 4*previous
  localparam int SUM_W        = SAMPLE_BITS + 3;

  // floor(x/5) == (x*52429) >> 18, exact for x < 2^16
  localparam int DIV5_MUL_W   = 16;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 16'd52429;
  localparam int DIV5_SHIFT   = 18;

  localparam logic [SAMPLE_BITS-1:0] HOLD_FLOOR     = 12'd1000;
  localparam logic [STAMP_W-1:0]     FREEZE_MS      = 32'd3000;
  localparam logic [STAMP_W-1:0]     OPEN_DELAY_MS  = 32'd500;
  localparam logic [STAMP_W-1:0]     RELEASE_GAP_MS = 32'd100;

  localparam logic [SAMPLE_BITS-1:0] WIN_LOW_RST    = 12'd2000;
  localparam logic [SAMPLE_BITS-1:0] WIN_HIGH_RST   = 12'd4095;

  // pump / channel numbering
  localparam int PUMP_RIGHT = 0;
  localparam int PUMP_LEFT  = 1;
  localparam int PUMP_ARM   = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_HIGH = 3'd5;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] low;
    logic [SAMPLE_BITS-1:0] high;
  } window_t;

endpackage

`default_nettype wire

// ===== sv/pchd_filter.sv =====
// pchd_filter: one low-pass filter lane, f = floor((sample + 4*prev)/5).
// Depends on pchd_pkg.
`default_nettype none

module pchd_filter import pchd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SAMPLE_BITS-1:0] filt_o
);

  logic [SAMPLE_BITS-1:0]          prev_q, prev_d;
  logic [SUM_W-1:0]                sum;
  logic [SUM_W+DIV5_MUL_W-1:0]     prod;

  assign sum    = {3'b000, sample_i} + {1'b0, prev_q, 2'b00};
  // divide by 5 through the reciprocal
  assign prod   = {{DIV5_MUL_W{1'b0}}, sum} * {{SUM_W{1'b0}}, DIV5_MUL};
  assign prev_d = prod[DIV5_SHIFT +: SAMPLE_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (en_i) begin
      prev_q <= prev_d;
    end
  end

  assign filt_o = prev_q;

endmodule

`default_nettype wire

// ===== sv/pchd_judge.sv =====
// pchd_judge: hold decision lane of one pump, with its timestamps and hold flag.
// Depends on pchd_pkg.
`default_nettype none

module pchd_judge import pchd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [SAMPLE_BITS-1:0] cur_i,
  input  logic                   open_i,
  input  logic [STAMP_W-1:0]     now_i,
  input  window_t                win_i,
  output logic                   hold_o
);

  logic [SAMPLE_BITS-1:0] held_q, held_d;
  logic [STAMP_W-1:0]     last_q, last_d;
  logic [STAMP_W-1:0]     start_q, start_d;
  logic [STAMP_W-1:0]     rel_q, rel_d;
  logic                   hold_q, hold_d;
  logic                   frozen, in_win, released;

  always_comb begin
    last_d  = (cur_i != held_q) ? now_i : last_q;
    held_d  = held_q;
    start_d = start_q;
    rel_d   = rel_q;
    hold_d  = hold_q;
    // 32-bit sums wrap before the compare
    frozen   = now_i > (last_d + FREEZE_MS);
    in_win   = (cur_i > HOLD_FLOOR) && (cur_i < win_i.low);
    released = (cur_i > win_i.high) || (cur_i < HOLD_FLOOR);
    if (!frozen) begin
      held_d = cur_i;
      if (in_win) begin
        if (!open_i) begin
          start_d = now_i;
        end
        if (open_i && (now_i > (start_q + OPEN_DELAY_MS)) &&
            (now_i > (rel_q + RELEASE_GAP_MS))) begin
          hold_d = 1'b1;
        end
      end else if (released) begin
        rel_d  = now_i;
        hold_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      last_q  <= '0;
      start_q <= '0;
      rel_q   <= '0;
      hold_q  <= 1'b0;
    end else if (en_i) begin
      held_q  <= held_d;
      last_q  <= last_d;
      start_q <= start_d;
      rel_q   <= rel_d;
      hold_q  <= hold_d;
    end
  end

  assign hold_o = hold_q;

endmodule

`default_nettype wire

// ===== sv/pump_current_hold_detector.sv =====
// pump_current_hold_detector: top level, filter lanes, decision lanes, output register
// and window registers. Depends on pchd_pkg, pchd_filter and pchd_judge.
`default_nettype none

// Accepts one transfer per clock and returns one result per transfer, in order.
// The first stage runs the filter lanes (one reciprocal multiply per channel, whose
// register is the filter's own state), the second runs the three decision lanes
// side by side and the merging output register packs the filtered currents and
// hold flags into one result. Sustained rate is one item per cycle; when the output
// stalls, one more item is taken into the filter stage and in_ready_o then drops
// until the output moves. Window registers take writes at any time (cfg_ready_o is
// always high); indexes beyond the last register are ignored. Stage A payload and
// output data registers have no reset; all else resets, with no clearing pass.
module pump_current_hold_detector import pchd_pkg::*; #(
  parameter int NumChannels = NUM_CHANNELS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_ch0_i,
  input  logic [SAMPLE_BITS-1:0] sample_ch1_i,
  input  logic [SAMPLE_BITS-1:0] sample_ch2_i,
  input  logic                   arm_open_i,
  input  logic                   left_open_i,
  input  logic                   right_open_i,
  input  logic [STAMP_W-1:0]     now_ms_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] filtered_ch0_o,
  output logic [SAMPLE_BITS-1:0] filtered_ch1_o,
  output logic [SAMPLE_BITS-1:0] filtered_ch2_o,
  output logic                   arm_holding_o,
  output logic                   left_holding_o,
  output logic                   right_holding_o,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i
);

  // handshake and stage control
  logic en_a, en_b, in_xfer;
  logic a_valid_q;
  logic out_valid_q;

  // stage A payload besides the filter state
  logic [NPUMP-1:0]       a_open_q;
  logic [STAMP_W-1:0]     a_t_q;

  logic [SAMPLE_BITS-1:0] sample [NPUMP];
  logic [SAMPLE_BITS-1:0] filt   [NPUMP];
  logic [SAMPLE_BITS-1:0] out_filt_q [NPUMP];
  logic [NPUMP-1:0]       hold;

  window_t win_q [NPUMP];

  // output side frees when empty or taken; stage A frees when empty or moving on
  assign en_b       = !out_valid_q || out_ready_i;
  assign en_a       = !a_valid_q || en_b;
  assign in_ready_o = en_a;
  assign in_xfer    = in_valid_i && en_a;

  assign sample[PUMP_RIGHT] = sample_ch0_i;
  assign sample[PUMP_LEFT]  = sample_ch1_i;
  assign sample[PUMP_ARM]   = sample_ch2_i;

  // filter lanes; channels beyond NumChannels read as zero
  for (genvar i = 0; i < NPUMP; i++) begin : g_filt
    if (i < NumChannels) begin : g_lane
      pchd_filter u_filter (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (in_xfer),
        .sample_i (sample[i]),
        .filt_o   (filt[i])
      );
    end else begin : g_zero
      assign filt[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid_q <= in_valid_i;
      end
      if (en_b) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_open_q <= {arm_open_i, left_open_i, right_open_i};
      a_t_q    <= now_ms_i;
    end
  end

  // decision lanes run when the stage A item moves into the output register
  for (genvar i = 0; i < NPUMP; i++) begin : g_judge
    pchd_judge u_judge (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (a_valid_q && en_b),
      .cur_i  (filt[i]),
      .open_i (a_open_q[i]),
      .now_i  (a_t_q),
      .win_i  (win_q[i]),
      .hold_o (hold[i])
    );
  end

  // merging stage: filtered values join the hold flags, which are lane registers
  always_ff @(posedge clk_i) begin
    if (a_valid_q && en_b) begin
      for (int i = 0; i < NPUMP; i++) begin
        out_filt_q[i] <= filt[i];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign filtered_ch0_o  = out_filt_q[PUMP_RIGHT];
  assign filtered_ch1_o  = out_filt_q[PUMP_LEFT];
  assign filtered_ch2_o  = out_filt_q[PUMP_ARM];
  assign arm_holding_o   = hold[PUMP_ARM];
  assign left_holding_o  = hold[PUMP_LEFT];
  assign right_holding_o = hold[PUMP_RIGHT];

  // window registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NPUMP; i++) begin
        win_q[i].low  <= WIN_LOW_RST;
        win_q[i].high <= WIN_HIGH_RST;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ARM_LOW:    win_q[PUMP_ARM].low    <= cfg_data_i;
        REG_ARM_HIGH:   win_q[PUMP_ARM].high   <= cfg_data_i;
        REG_LEFT_LOW:   win_q[PUMP_LEFT].low   <= cfg_data_i;
        REG_LEFT_HIGH:  win_q[PUMP_LEFT].high  <= cfg_data_i;
        REG_RIGHT_LOW:  win_q[PUMP_RIGHT].low  <= cfg_data_i;
        REG_RIGHT_HIGH: win_q[PUMP_RIGHT].high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage A item is never dropped while the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !en_b |=> a_valid_q)
    else $error("stage A item lost under output stall");

  // an accepted transfer always lands in stage A
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> a_valid_q)
    else $error("accepted transfer missing from stage A");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output");

  // arm hold only sets while the arm pump was open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(arm_holding_o) |-> $past(a_open_q[PUMP_ARM]))
    else $error("arm hold set with pump closed");

endmodule

`default_nettype wire

// ===== dv/pump_current_hold_detector_tb.sv =====
// pump_current_hold_detector_tb: self-checking bench for the pump current hold detector.
// Predicts filtered currents and hold flags per transfer and checks every result in order.
// Depends on pchd_pkg and pump_current_hold_detector.

module pump_current_hold_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pchd_pkg::*;

  // Indexes past the last window register; the block must drop these writes.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // One input transfer. Samples are indexed by channel, pump flags by pump
  // number; channel n feeds pump n (0 right, 1 left, 2 arm).
  typedef struct packed {
    logic [NPUMP-1:0][SAMPLE_BITS-1:0] sample;
    logic [NPUMP-1:0]                  pump_on;
    logic [STAMP_W-1:0]                now_ms;
  } sample_item_t;

  // One result transfer, same indexing.
  typedef struct packed {
    logic [NPUMP-1:0][SAMPLE_BITS-1:0] current;
    logic [NPUMP-1:0]                  holding;
  } pump_result_t;

  // Receiver back-pressure styles, switched at random intervals.
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  // Scoreboard: keeps its own copy of the window registers and the per-pump
  // tracking state, predicts each result when a sample transfer is accepted
  // and checks results against the oldest prediction.
  class hold_scoreboard;
    logic [SAMPLE_BITS-1:0] win_low        [NPUMP];
    logic [SAMPLE_BITS-1:0] win_high       [NPUMP];
    logic [SAMPLE_BITS-1:0] last_filt      [NPUMP];
    logic [SAMPLE_BITS-1:0] steady_current [NPUMP];
    logic [STAMP_W-1:0]     change_ms      [NPUMP];
    logic [STAMP_W-1:0]     closed_ms      [NPUMP];
    logic [STAMP_W-1:0]     release_ms     [NPUMP];
    logic                   hold_state     [NPUMP];
    string                  pump_name      [NPUMP];
    pump_result_t           predicted_results [$];
    int unsigned            mismatches;

    function new();
      for (int p = 0; p < NPUMP; p++) begin
        win_low[p]        = WIN_LOW_RST;
        win_high[p]       = WIN_HIGH_RST;
        last_filt[p]      = '0;
        steady_current[p] = '0;
        change_ms[p]      = '0;
        closed_ms[p]      = '0;
        release_ms[p]     = '0;
        hold_state[p]     = 1'b0;
      end
      pump_name[PUMP_RIGHT] = "right";
      pump_name[PUMP_LEFT]  = "left";
      pump_name[PUMP_ARM]   = "arm";
      mismatches = 0;
    endfunction

    function void write_window(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_BITS-1:0] value);
      case (idx)
        REG_ARM_LOW:    win_low[PUMP_ARM]    = value;
        REG_ARM_HIGH:   win_high[PUMP_ARM]   = value;
        REG_LEFT_LOW:   win_low[PUMP_LEFT]   = value;
        REG_LEFT_HIGH:  win_high[PUMP_LEFT]  = value;
        REG_RIGHT_LOW:  win_low[PUMP_RIGHT]  = value;
        REG_RIGHT_HIGH: win_high[PUMP_RIGHT] = value;
        default: ;
      endcase
    endfunction

    // Hold decision of one pump for filtered current c at time t.
    // All stamp sums wrap at 32 bits before the compare.
    function void judge_pump(int p, logic [SAMPLE_BITS-1:0] c, logic on, logic [STAMP_W-1:0] t);
      logic [STAMP_W-1:0] freeze_at;
      logic [STAMP_W-1:0] open_at;
      logic [STAMP_W-1:0] rearm_at;
      if (c != steady_current[p]) change_ms[p] = t;
      freeze_at = change_ms[p] + FREEZE_MS;
      if (t > freeze_at) return;       // current stuck too long: decision frozen
      steady_current[p] = c;
      open_at  = closed_ms[p] + OPEN_DELAY_MS;
      rearm_at = release_ms[p] + RELEASE_GAP_MS;
      if (c > HOLD_FLOOR && c < win_low[p]) begin
        if (!on) begin
          closed_ms[p] = t;
        end else if (t > open_at && t > rearm_at) begin
          hold_state[p] = 1'b1;
        end
      end else if (c > win_high[p] || c < HOLD_FLOOR) begin
        release_ms[p] = t;
        hold_state[p] = 1'b0;
      end
    endfunction

    function void note_sample(sample_item_t it);
      logic [SUM_W-1:0] acc;
      pump_result_t     r;
      for (int p = 0; p < NPUMP; p++) begin
        // floor((sample + 4*previous) / 5)
        acc          = SUM_W'(it.sample[p]) + (SUM_W'(last_filt[p]) << 2);
        last_filt[p] = SAMPLE_BITS'(acc / 5);
        r.current[p] = last_filt[p];
        judge_pump(p, last_filt[p], it.pump_on[p], it.now_ms);
      end
      for (int p = 0; p < NPUMP; p++) r.holding[p] = hold_state[p];
      predicted_results.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(pump_result_t got);
      pump_result_t want;
      if (predicted_results.size() == 0) begin
        report("result transfer with no prediction pending");
      end else begin
        want = predicted_results.pop_front();
        for (int p = 0; p < NPUMP; p++) begin
          if (got.current[p] !== want.current[p])
            report($sformatf("filtered_ch%0d got %0d, expected %0d",
                             p, got.current[p], want.current[p]));
          if (got.holding[p] !== want.holding[p])
            report($sformatf("%s_holding got %0b, expected %0b",
                             pump_name[p], got.holding[p], want.holding[p]));
        end
      end
    endtask

    function int unsigned pending();
      return predicted_results.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid   = 1'b0;
  logic [SAMPLE_BITS-1:0] sample_ch0 = '0;
  logic [SAMPLE_BITS-1:0] sample_ch1 = '0;
  logic [SAMPLE_BITS-1:0] sample_ch2 = '0;
  logic                   arm_open   = 1'b0;
  logic                   left_open  = 1'b0;
  logic                   right_open = 1'b0;
  logic [STAMP_W-1:0]     now_ms     = '0;
  logic                   out_ready  = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [SAMPLE_BITS-1:0] cfg_data   = '0;

  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [SAMPLE_BITS-1:0] filtered_ch0_o;
  logic [SAMPLE_BITS-1:0] filtered_ch1_o;
  logic [SAMPLE_BITS-1:0] filtered_ch2_o;
  logic                   arm_holding_o;
  logic                   left_holding_o;
  logic                   right_holding_o;
  logic                   cfg_ready_o;

  hold_scoreboard sb;

  // Window values currently programmed, used to steer stimulus levels.
  logic [SAMPLE_BITS-1:0] win_lo_cur [NPUMP] = '{WIN_LOW_RST, WIN_LOW_RST, WIN_LOW_RST};
  logic [SAMPLE_BITS-1:0] win_hi_cur [NPUMP] = '{WIN_HIGH_RST, WIN_HIGH_RST, WIN_HIGH_RST};

  // Remaining transfers in the current sender burst.
  int unsigned burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pump_current_hold_detector dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .sample_ch0_i    (sample_ch0),
    .sample_ch1_i    (sample_ch1),
    .sample_ch2_i    (sample_ch2),
    .arm_open_i      (arm_open),
    .left_open_i     (left_open),
    .right_open_i    (right_open),
    .now_ms_i        (now_ms),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .filtered_ch0_o  (filtered_ch0_o),
    .filtered_ch1_o  (filtered_ch1_o),
    .filtered_ch2_o  (filtered_ch2_o),
    .arm_holding_o   (arm_holding_o),
    .left_holding_o  (left_holding_o),
    .right_holding_o (right_holding_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Receiver: back-pressure style changes at random intervals. Steady mode gives
  // long stretches with no stalls; periodic mode stalls in a repeating pattern.
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode  = RX_STEADY;
  int unsigned rx_count = 0;

  always @(posedge clk) begin
    if (rx_count == 0) begin
      rx_mode  <= rx_mode_e'($urandom_range(0, 3));
      rx_count <= $urandom_range(16, 96);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      RX_STEADY:   out_ready <= 1'b1;
      RX_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:    out_ready <= ($urandom_range(0, 4) == 0);
      RX_PERIODIC: out_ready <= (rx_count[2:0] >= 3'd3);
      default:     out_ready <= 1'b1;
    endcase
  end

  // Result monitor: values read right after the edge are the ones the block
  // saw at that edge, since everything here is driven nonblocking.
  always @(posedge clk) begin : result_monitor
    pump_result_t seen;
    if (rst_n && out_valid_o && out_ready) begin
      seen.current[PUMP_RIGHT] = filtered_ch0_o;
      seen.current[PUMP_LEFT]  = filtered_ch1_o;
      seen.current[PUMP_ARM]   = filtered_ch2_o;
      seen.holding[PUMP_RIGHT] = right_holding_o;
      seen.holding[PUMP_LEFT]  = left_holding_o;
      seen.holding[PUMP_ARM]   = arm_holding_o;
      sb.check_result(seen);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one sample transfer and wait for it to be taken. Bursts of random
  // length are separated by random gaps; valid only drops at a burst end.
  task automatic push_sample(sample_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    sample_ch0 <= it.sample[PUMP_RIGHT];
    sample_ch1 <= it.sample[PUMP_LEFT];
    sample_ch2 <= it.sample[PUMP_ARM];
    right_open <= it.pump_on[PUMP_RIGHT];
    left_open  <= it.pump_on[PUMP_LEFT];
    arm_open   <= it.pump_on[PUMP_ARM];
    now_ms     <= it.now_ms;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    sb.note_sample(it);
    burst_left--;
  endtask

  // Stop sending and let every pending result come out, then let the two-stage
  // pipe settle.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all six window registers, then both spare indexes with junk.
  // Only called with the block idle.
  task automatic program_windows(logic [SAMPLE_BITS-1:0] arm_lo, arm_hi,
                                 logic [SAMPLE_BITS-1:0] left_lo, left_hi,
                                 logic [SAMPLE_BITS-1:0] right_lo, right_hi);
    logic [CFG_IDX_W-1:0]   idx_list [8];
    logic [SAMPLE_BITS-1:0] val_list [8];
    idx_list = '{REG_ARM_LOW, REG_ARM_HIGH, REG_LEFT_LOW, REG_LEFT_HIGH,
                 REG_RIGHT_LOW, REG_RIGHT_HIGH, REG_SPARE_A, REG_SPARE_B};
    val_list = '{arm_lo, arm_hi, left_lo, left_hi, right_lo, right_hi,
                 SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom())};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      @(posedge clk);
      while (!cfg_ready_o) @(posedge clk);
      sb.write_window(idx_list[i], val_list[i]);
    end
    cfg_valid <= 1'b0;
    win_lo_cur[PUMP_ARM]   = arm_lo;
    win_hi_cur[PUMP_ARM]   = arm_hi;
    win_lo_cur[PUMP_LEFT]  = left_lo;
    win_hi_cur[PUMP_LEFT]  = left_hi;
    win_lo_cur[PUMP_RIGHT] = right_lo;
    win_hi_cur[PUMP_RIGHT] = right_hi;
  endtask

  // Pick a target current for one pump: below the floor, inside the holding
  // window, between the window bounds, above the release bound, or exactly on
  // a boundary (the filter settles exactly on a level approached from above).
  function automatic logic [SAMPLE_BITS-1:0] pick_level(int p);
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] level;
    lo = win_lo_cur[p];
    hi = win_hi_cur[p];
    case ($urandom_range(0, 4))
      0: level = SAMPLE_BITS'($urandom_range(0, 999));
      1: level = (lo > 12'd1002) ? SAMPLE_BITS'($urandom_range(1001, lo - 1))
                                 : SAMPLE_BITS'($urandom_range(1001, 1100));
      2: level = (hi > lo) ? SAMPLE_BITS'($urandom_range(lo, hi))
                           : SAMPLE_BITS'($urandom_range(1000, 4095));
      3: level = (hi < 12'd4095) ? SAMPLE_BITS'($urandom_range(hi + 1, 4095)) : 12'd4095;
      default: begin
        case ($urandom_range(0, 2))
          0:       level = HOLD_FLOOR;
          1:       level = lo;
          default: level = hi;
        endcase
      end
    endcase
    return level;
  endfunction

  // Directed opening: freeze right after reset, full-scale and zero samples,
  // timestamp at all ones (wrap makes the freeze test pass early), a ramp into
  // the holding window with pumps closed, then open long enough to hold, a
  // large time jump, and a drop below the floor that releases.
  task automatic run_directed();
    sample_item_t       it;
    logic [STAMP_W-1:0] t;
    // current stays at its reset value for more than 3000 ms: frozen
    it.sample  = '0;
    it.pump_on = '0;
    it.now_ms  = 32'd5000;
    push_sample(it);
    it.sample  = {NPUMP{12'd4095}};
    it.now_ms  = '0;
    push_sample(it);
    it.sample  = '0;
    it.pump_on = '1;
    it.now_ms  = '1;
    push_sample(it);
    // ramp toward 1500..1700 with pumps closed: sets the closed stamps
    t = 32'd1000;
    for (int k = 0; k < 8; k++) begin
      t += 32'd50;
      it.sample  = {12'd1700, 12'd1600, 12'd1500};
      it.pump_on = '0;
      it.now_ms  = t;
      push_sample(it);
    end
    // pumps open: hold sets once 500 ms have passed
    for (int k = 0; k < 6; k++) begin
      t += 32'd200;
      it.pump_on = '1;
      it.now_ms  = t;
      push_sample(it);
    end
    t += 32'd4000;
    it.now_ms = t;
    push_sample(it);
    // currents fall below the floor: release
    for (int k = 0; k < 3; k++) begin
      t += 32'd20;
      it.sample = '0;
      it.now_ms = t;
      push_sample(it);
    end
  endtask

  // Random traffic: per pump a target level that moves now and then, small
  // jitter or none (so the freeze can trigger), pump flags that toggle
  // rarely, and a clock that mostly creeps forward with occasional stalls,
  // long jumps and jumps to a random stamp. A few transfers are pure noise.
  task automatic run_random(int unsigned count, logic [STAMP_W-1:0] start_ms);
    sample_item_t           it;
    logic [SAMPLE_BITS-1:0] level  [NPUMP];
    logic                   steady [NPUMP];
    logic [NPUMP-1:0]       on;
    logic [STAMP_W-1:0]     t;
    int unsigned            roll;
    int                     s;
    t  = start_ms;
    on = NPUMP'($urandom());
    for (int p = 0; p < NPUMP; p++) begin
      level[p]  = pick_level(p);
      steady[p] = 1'($urandom_range(0, 1));
    end
    repeat (count) begin
      for (int p = 0; p < NPUMP; p++) begin
        if ($urandom_range(0, 24) == 0) begin
          level[p]  = pick_level(p);
          steady[p] = 1'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 19) == 0) on[p] = ~on[p];
      end
      roll = $urandom_range(0, 99);
      if (roll < 70)      t += $urandom_range(0, 150);
      else if (roll < 88) t += $urandom_range(150, 700);
      else if (roll < 93) t += 32'd0;
      else if (roll < 97) t += $urandom_range(3001, 6000);
      else                t  = $urandom();
      for (int p = 0; p < NPUMP; p++) begin
        s = int'(level[p]);
        if (!steady[p]) s = s + int'($urandom_range(0, 6)) - 3;
        if (s < 0)    s = 0;
        if (s > 4095) s = 4095;
        it.sample[p] = SAMPLE_BITS'(s);
      end
      it.pump_on = on;
      it.now_ms  = t;
      if ($urandom_range(0, 19) == 0) begin
        for (int p = 0; p < NPUMP; p++) it.sample[p] = SAMPLE_BITS'($urandom_range(0, 4095));
        it.pump_on = NPUMP'($urandom());
      end
      push_sample(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset windows
    run_directed();
    run_random(130, 32'd0);
    drain();

    // narrow window, release band in reach; clock starts near the wrap
    program_windows(12'd2500, 12'd3000, 12'd2500, 12'd3000, 12'd2500, 12'd3000);
    run_random(130, 32'hFFFF_F000);
    drain();

    // extremes: all-full, all-zero, and an empty window at the floor
    program_windows(12'd4095, 12'd4095, 12'd0, 12'd0, 12'd1001, 12'd1000);
    run_random(130, $urandom());
    drain();

    // one-value window, inverted bounds
    program_windows(12'd1002, 12'd1001, 12'd4095, 12'd0, 12'd3000, 12'd2000);
    run_random(130, 32'hFFFF_FC00);
    drain();

    // fully random windows
    program_windows(SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()),
                    SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()),
                    SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()));
    run_random(130, $urandom());
    drain();

    // mixed ordinary settings
    program_windows(12'd3500, 12'd3600, 12'd1500, 12'd2500, 12'd2000, 12'd4095);
    run_random(130, 32'd100);
    drain();

    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (~800 transfers, each with a
  // full sender gap and a long receiver stall).
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
sv/pchd_pkg.sv
sv/pchd_filter.sv
sv/pchd_judge.sv
sv/pump_current_hold_detector.sv
dv/pump_current_hold_detector_tb.sv
